// ===== hw/rtl/biquad_band_stop_filter_assert.svh =====
// ----------------------------------------------------------------------------
// biquad band-stop filter assertion macros
// clocked property wrappers used by the filter rtl
// ----------------------------------------------------------------------------
`ifndef BIQUAD_BAND_STOP_FILTER_ASSERT_SVH
`define BIQUAD_BAND_STOP_FILTER_ASSERT_SVH

// checked at every clock edge outside reset
`define BSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every clock edge, reset included
`define BSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/bsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bsf_pkg
// register indexes and shared types of the biquad band-stop filter
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int unsigned RegIdxBits = 3;

  typedef enum logic [RegIdxBits-1:0] {
    REG_COEF_B0 = 3'd0,
    REG_COEF_B1 = 3'd1,
    REG_COEF_A1 = 3'd2,
    REG_COEF_A2 = 3'd3,
    REG_BYPASS  = 3'd4
  } bsf_reg_e;

  // startup counter saturates here; from then on the filter runs
  localparam logic [1:0] PrimeCount = 2'd2;

  typedef struct packed {
    logic bypass;
    logic primed;
  } bsf_mode_t;

endpackage

// ===== hw/rtl/biquad_band_stop_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_band_stop_filter
// direct-form-I band-stop biquad, one 16-bit sample in, one sample out
// dataflow: an accepted sample is held in the input register, then moves
//   into the result register when it advances; the output is registered
// throughput: 1 item per cycle unless the output stalls; the feedback path
//   (five products, sum, round, saturate) is combinational into history regs
// reset: asynchronous, active low; coefficients clear, bypass sets,
//   histories and startup counter clear, no items in flight
// ----------------------------------------------------------------------------
module biquad_band_stop_filter #(
  parameter int unsigned COEF_FRAC_BITS = 14,
  parameter int unsigned SAMPLE_BITS    = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [bsf_pkg::RegIdxBits-1:0]         cfg_idx_i,
  input  logic [COEF_FRAC_BITS+3:0]              cfg_data_i,
  // input samples
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // sample_in
  // output samples
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata   // sample_out
);
  import bsf_pkg::*;

  localparam int unsigned CoefBits  = COEF_FRAC_BITS + 4;
  localparam int unsigned TdataBits = ((SAMPLE_BITS + 7) / 8) * 8;

  logic signed [CoefBits-1:0] b0_q, b1_q, a1_q, a2_q;
  logic                       bypass_q;

  logic                          in_valid_q, out_valid_q;
  logic signed [SAMPLE_BITS-1:0] x_q, y_q, y_d;
  logic signed [SAMPLE_BITS-1:0] x1, x2, y1, y2;
  logic                          primed;
  logic                          advance;
  bsf_mode_t                     mode;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q     <= '0;
      b1_q     <= '0;
      a1_q     <= '0;
      a2_q     <= '0;
      bypass_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COEF_B0: b0_q     <= cfg_data_i;
        REG_COEF_B1: b1_q     <= cfg_data_i;
        REG_COEF_A1: a1_q     <= cfg_data_i;
        REG_COEF_A2: a2_q     <= cfg_data_i;
        REG_BYPASS:  bypass_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // item moves from input register to result register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      x_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
    if (advance) begin
      y_q <= y_d;
    end
  end

  bsf_history #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_history (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .x_i      (x_q),
    .y_i      (y_d),
    .x1_o     (x1),
    .x2_o     (x2),
    .y1_o     (y1),
    .y2_o     (y2),
    .primed_o (primed)
  );

  assign mode.bypass = bypass_q;
  assign mode.primed = primed;

  bsf_mac #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_mac (
    .mode_i(mode),
    .b0_i  (b0_q),
    .b1_i  (b1_q),
    .a1_i  (a1_q),
    .a2_i  (a2_q),
    .x_i   (x_q),
    .x1_i  (x1),
    .x2_i  (x2),
    .y1_i  (y1),
    .y2_i  (y2),
    .y_o   (y_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TdataBits'(unsigned'(y_q));

  `include "biquad_band_stop_filter_assert.svh"

  `BSF_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !m_axis_tvalid, "result valid during reset")
  `BSF_ASSERT(a_stall_blocks, (in_valid_q && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "input taken while both stages full")
  `BSF_ASSERT(a_primed_stays, primed |=> primed, "startup state dropped after priming")
  `BSF_ASSERT(a_bypass_pass, (advance && bypass_q) |=> (y_q == $past(x_q)), "bypass item altered")
  `BSF_ASSERT(a_hist_shift, advance |=> (x1 == $past(x_q) && x2 == $past(x1)), "input history not shifted")

endmodule

// ===== hw/rtl/bsf_history.sv =====
// ----------------------------------------------------------------------------
// bsf_history
// two-deep input and output delay lines plus the startup counter
// ----------------------------------------------------------------------------
module bsf_history #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic signed [SAMPLE_BITS-1:0] y_i,
  output logic signed [SAMPLE_BITS-1:0] x1_o,
  output logic signed [SAMPLE_BITS-1:0] x2_o,
  output logic signed [SAMPLE_BITS-1:0] y1_o,
  output logic signed [SAMPLE_BITS-1:0] y2_o,
  output logic                          primed_o
);
  import bsf_pkg::*;

  logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, y1_q, y2_q;
  logic [1:0] cnt_q, cnt_d;

  assign primed_o = (cnt_q == PrimeCount);
  assign cnt_d    = primed_o ? cnt_q : cnt_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q  <= '0;
      x2_q  <= '0;
      y1_q  <= '0;
      y2_q  <= '0;
      cnt_q <= '0;
    end else if (advance_i) begin
      x1_q  <= x_i;
      x2_q  <= x1_q;
      y1_q  <= y_i;
      y2_q  <= y1_q;
      cnt_q <= cnt_d;
    end
  end

  assign x1_o = x1_q;
  assign x2_o = x2_q;
  assign y1_o = y1_q;
  assign y2_o = y2_q;

endmodule

// ===== hw/rtl/bsf_mac.sv =====
// ----------------------------------------------------------------------------
// bsf_mac
// five parallel products, exact sum, rounding, saturation and pass-through
// ----------------------------------------------------------------------------
module bsf_mac #(
  parameter int unsigned COEF_FRAC_BITS = 14,
  parameter int unsigned SAMPLE_BITS    = 16
) (
  input  bsf_pkg::bsf_mode_t                mode_i,
  input  logic signed [COEF_FRAC_BITS+3:0]  b0_i,
  input  logic signed [COEF_FRAC_BITS+3:0]  b1_i,
  input  logic signed [COEF_FRAC_BITS+3:0]  a1_i,
  input  logic signed [COEF_FRAC_BITS+3:0]  a2_i,
  input  logic signed [SAMPLE_BITS-1:0]     x_i,
  input  logic signed [SAMPLE_BITS-1:0]     x1_i,
  input  logic signed [SAMPLE_BITS-1:0]     x2_i,
  input  logic signed [SAMPLE_BITS-1:0]     y1_i,
  input  logic signed [SAMPLE_BITS-1:0]     y2_i,
  output logic signed [SAMPLE_BITS-1:0]     y_o
);
  import bsf_pkg::*;

  localparam int unsigned CoefBits = COEF_FRAC_BITS + 4;
  localparam int unsigned ProdBits = CoefBits + SAMPLE_BITS;
  localparam int unsigned AccBits  = ProdBits + 3;

  localparam logic signed [AccBits-1:0] SMax =
    {{(AccBits-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [AccBits-1:0] SMin =
    {{(AccBits-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [AccBits-1:0] RoundHalf =
    AccBits'(1) << (COEF_FRAC_BITS - 1);

  logic signed [ProdBits-1:0] p_b0x, p_b1x1, p_b0x2, p_a1y1, p_a2y2;
  logic signed [AccBits-1:0]  acc, acc_rnd, acc_sh;
  logic signed [SAMPLE_BITS-1:0] y_filt;

  assign p_b0x  = b0_i * x_i;
  assign p_b1x1 = b1_i * x1_i;
  assign p_b0x2 = b0_i * x2_i;
  assign p_a1y1 = a1_i * y1_i;
  assign p_a2y2 = a2_i * y2_i;

  assign acc = AccBits'(p_b0x) + AccBits'(p_b1x1) + AccBits'(p_b0x2)
             - AccBits'(p_a1y1) - AccBits'(p_a2y2);

  // round half up, then back to sample scale
  assign acc_rnd = acc + RoundHalf;
  assign acc_sh  = acc_rnd >>> COEF_FRAC_BITS;

  always_comb begin
    if (acc_sh > SMax) begin
      y_filt = SMax[SAMPLE_BITS-1:0];
    end else if (acc_sh < SMin) begin
      y_filt = SMin[SAMPLE_BITS-1:0];
    end else begin
      y_filt = acc_sh[SAMPLE_BITS-1:0];
    end
  end

  assign y_o = (mode_i.bypass || !mode_i.primed) ? x_i : y_filt;

endmodule
